### hdl/b3s23_cellular_automaton_grid_defines.svh
// assertion macros for the b3s23 grid checker
// depends on nothing; include once per file that asserts
`ifndef B3S23_CELLULAR_AUTOMATON_GRID_DEFINES_SVH
`define B3S23_CELLULAR_AUTOMATON_GRID_DEFINES_SVH

// antecedent implies consequent in the next cycle
`define B3S_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b3s23 check failed");

// expression holds at every edge out of reset
`define B3S_ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("b3s23 check failed");

`endif

### hdl/b3s_pkg.sv
// types and constants for the b3s23 cellular automaton grid
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b3s_pkg;

  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 64;
  localparam int INDEX_W      = 11;
  localparam int ROW_W        = 6;
  localparam int COL_W        = 7;
  localparam int GEN_W        = 16;

  localparam logic [ROW_W-1:0] ROW_RESET = 6'd30;
  localparam logic [COL_W-1:0] COL_RESET = 7'd60;

  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [3:0] SELF_SLOT = 4'd4;
  localparam logic [3:0] LAST_SLOT = 4'd9;
  localparam logic [3:0] BIRTH_CNT = 4'd3;
  localparam logic [3:0] KEEP_LO   = 4'd2;
  localparam logic [3:0] KEEP_HI   = 4'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [INDEX_W-1:0] cell_index;
    logic               cell_value;
  } in_word_t;

  typedef struct packed {
    logic             read_value;
    logic [GEN_W-1:0] generation;
  } out_word_t;

endpackage

`default_nettype wire

### hdl/b3s23_cellular_automaton_grid.sv
// b3s23 cellular automaton grid: two one-bit cell memories, ping-pong per generation
// depends on b3s_pkg
//
// usage: input words carry kind, cell_index, cell_value on a valid/stall channel;
// every accepted word gives exactly one output word (read_value, generation).
// a write, a read or an unused kind passes through S_FIN to the output register.
// an advance sweeps every cell of the current grid; for each cell it does
// nine reads of one memory port, then one write to the other buffer, and then
// its result passes through S_FIN to the output register.
// one word is in flight at a time; in_stall_o is high while it is worked on.
// the output register holds a finished word while out_stall_i is high, and the
// next input word is taken meanwhile; its result waits for the register.
// after reset both memories are cleared one entry per cycle, all MAX_ROWS * MAX_COLS
// entries, with in_stall_o high; configuration writes are taken at any time.
// rows and cols are set over the apb port at byte addresses 0 and 4.
`timescale 1ns / 1ps
`default_nettype none

module b3s23_cellular_automaton_grid #(
  parameter int MAX_ROWS = b3s_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = b3s_pkg::MAX_COLS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire b3s_pkg::in_word_t in_word_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output b3s_pkg::out_word_t     out_word_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam int WW    = (CW > b3s_pkg::INDEX_W) ? CW : b3s_pkg::INDEX_W;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int KW    = $clog2(MAX_COLS + 1);

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_GEN  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic mem_even [DEPTH];
  logic mem_odd  [DEPTH];

  logic [1:0]                   state_q, state_d;
  logic [b3s_pkg::ROW_W-1:0]    rows_q;
  logic [b3s_pkg::COL_W-1:0]    cols_q;
  logic [b3s_pkg::GEN_W-1:0]    gen_q, gen_d;
  logic [AW-1:0]                clr_q, clr_d;
  logic [CW-1:0]                p_q, p_d;
  logic [3:0]                   k_q, k_d;
  logic [3:0]                   cnt_q, cnt_d;
  logic                         self_q, self_d;
  logic [1:0]                   kind_q, kind_d;
  logic                         hit_q, hit_d;
  logic                         reven_q, rodd_q;
  logic                         out_valid_q, out_valid_d;
  b3s_pkg::out_word_t           out_q, out_d;

  logic [RW-1:0] rows_used;
  logic [KW-1:0] cols_used;
  logic [CW-1:0] cells, cols_w, rb, q;
  logic          accept, in_range, rd_en, we_even, we_odd, wdata, cur_bit, next_bit;
  logic [AW-1:0] rd_addr, waddr;
  logic [3:0]    total;
  logic [1:0]    dr_sel, dc_sel;

  // configuration
  assign pready = 1'b1;
  always_comb begin
    prdata = (paddr[2] == b3s_pkg::REG_COLS) ? 32'(cols_q) : 32'(rows_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= b3s_pkg::ROW_RESET;
      cols_q <= b3s_pkg::COL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == b3s_pkg::REG_COLS) begin
        cols_q <= pwdata[b3s_pkg::COL_W-1:0];
      end else begin
        rows_q <= pwdata[b3s_pkg::ROW_W-1:0];
      end
    end
  end

  always_comb begin
    if (rows_q == '0) begin
      rows_used = RW'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      rows_used = RW'(MAX_ROWS);
    end else begin
      rows_used = RW'(rows_q);
    end
    if (cols_q == '0) begin
      cols_used = KW'(1);
    end else if (32'(cols_q) > MAX_COLS) begin
      cols_used = KW'(MAX_COLS);
    end else begin
      cols_used = KW'(cols_q);
    end
    cols_w = CW'(cols_used);
    cells  = CW'(rows_used) * cols_w;
  end

  // neighbor address: row step then column step, each wrapped once
  always_comb begin
    unique case (k_q)
      4'd0, 4'd1, 4'd2: dr_sel = 2'd0;
      4'd3, 4'd4, 4'd5: dr_sel = 2'd1;
      default:          dr_sel = 2'd2;
    endcase
    unique case (k_q)
      4'd0, 4'd3, 4'd6: dc_sel = 2'd0;
      4'd1, 4'd4, 4'd7: dc_sel = 2'd1;
      default:          dc_sel = 2'd2;
    endcase
    unique case (dr_sel)
      2'd0:    rb = (p_q >= cols_w) ? p_q - cols_w : p_q + cells - cols_w;
      2'd2:    rb = (p_q + cols_w >= cells) ? p_q + cols_w - cells : p_q + cols_w;
      default: rb = p_q;
    endcase
    unique case (dc_sel)
      2'd0:    q = (rb == '0) ? cells - CW'(1) : rb - CW'(1);
      2'd2:    q = (rb + CW'(1) == cells) ? '0 : rb + CW'(1);
      default: q = rb;
    endcase
  end

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_range   = WW'(in_word_i.cell_index) < WW'(cells);
  assign cur_bit    = gen_q[0] ? rodd_q : reven_q;
  assign total      = cnt_q + 4'(cur_bit);
  assign next_bit   = self_q ? (total == b3s_pkg::KEEP_LO || total == b3s_pkg::KEEP_HI)
                             : (total == b3s_pkg::BIRTH_CNT);

  always_comb begin
    state_d     = state_q;
    gen_d       = gen_q;
    clr_d       = clr_q;
    p_d         = p_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    self_d      = self_q;
    kind_d      = kind_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = AW'(q);
    we_even     = 1'b0;
    we_odd      = 1'b0;
    waddr       = AW'(p_q);
    wdata       = next_bit;
    unique case (state_q)
      S_CLR: begin
        we_even = 1'b1;
        we_odd  = 1'b1;
        waddr   = clr_q;
        wdata   = 1'b0;
        clr_d   = clr_q + AW'(1);
        if (32'(clr_q) == DEPTH - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          kind_d  = in_word_i.kind;
          hit_d   = in_range;
          rd_addr = AW'(in_word_i.cell_index);
          waddr   = AW'(in_word_i.cell_index);
          wdata   = in_word_i.cell_value;
          p_d     = '0;
          k_d     = '0;
          state_d = S_FIN;
          if (in_word_i.kind == b3s_pkg::KIND_WRITE && in_range) begin
            we_even = !gen_q[0];
            we_odd  = gen_q[0];
          end else if (in_word_i.kind == b3s_pkg::KIND_READ) begin
            rd_en = 1'b1;
          end else if (in_word_i.kind == b3s_pkg::KIND_ADVANCE) begin
            state_d = S_GEN;
          end
        end
      end
      S_GEN: begin
        if (k_q != b3s_pkg::LAST_SLOT) begin
          rd_en = 1'b1;
        end
        if (k_q == '0) begin
          cnt_d = '0;
        end else if (k_q - 4'd1 == b3s_pkg::SELF_SLOT) begin
          self_d = cur_bit;
        end else begin
          cnt_d = total;
        end
        k_d = k_q + 4'd1;
        if (k_q == b3s_pkg::LAST_SLOT) begin
          we_even = gen_q[0];
          we_odd  = !gen_q[0];
          k_d     = '0;
          p_d     = p_q + CW'(1);
          if (p_q + CW'(1) == cells) begin
            gen_d   = gen_q + 16'd1;
            state_d = S_FIN;
          end
        end
      end
      default: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d           = 1'b1;
          out_d.generation      = gen_q;
          out_d.read_value      = (kind_q == b3s_pkg::KIND_READ) && hit_q && cur_bit;
          state_d               = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      gen_q       <= '0;
      clr_q       <= '0;
      p_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_q       <= gen_d;
      clr_q       <= clr_d;
      p_q         <= p_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    self_q <= self_d;
    kind_q <= kind_d;
    hit_q  <= hit_d;
    out_q  <= out_d;
  end

  // cell memories
  always_ff @(posedge clk_i) begin
    if (we_even) begin
      mem_even[waddr] <= wdata;
    end
    if (rd_en) begin
      reven_q <= mem_even[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_odd) begin
      mem_odd[waddr] <= wdata;
    end
    if (rd_en) begin
      rodd_q <= mem_odd[rd_addr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

### hdl/b3s_checker.sv
// port-level checks for the b3s23 grid, bound to the top level
// depends on b3s23_cellular_automaton_grid_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "b3s23_cellular_automaton_grid_defines.svh"

module b3s_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic pready
);

  `B3S_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `B3S_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)
  `B3S_ASSERT_ALWAYS(a_pready_high, clk_i, rst_ni, pready)

endmodule

bind b3s23_cellular_automaton_grid b3s_checker u_b3s_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .pready      (pready)
);

`default_nettype wire
